### rtl/best_fit_bin_packer_assert.svh
// Assertion macros used by the bin packer datapath.
`ifndef BEST_FIT_BIN_PACKER_ASSERT_SVH
`define BEST_FIT_BIN_PACKER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define BFBP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bin packer check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define BFBP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bin packer check failed");

`endif

### rtl/bfbp_pkg.sv
// Shared widths and controller/datapath signal groups of the bin packer.
package bfbp_pkg;

    localparam int ID_W   = 16;
    localparam int SIZE_W = 31;
    localparam int IDX_W  = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

### rtl/bfbp_in_if.sv
// Request channel carrying one item to be placed.
interface bfbp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        start_run;
    logic [bfbp_pkg::ID_W-1:0]   item_id;
    logic [bfbp_pkg::SIZE_W-1:0] item_size;

    modport source (output valid, output start_run, output item_id, output item_size,
                    input ready);
    modport sink   (input valid, input start_run, input item_id, input item_size,
                    output ready);
endinterface

### rtl/bfbp_out_if.sv
// Result channel carrying one placement decision.
interface bfbp_out_if;
    logic                       valid;
    logic                       ready;
    logic [bfbp_pkg::ID_W-1:0]  placed_id;
    logic [bfbp_pkg::IDX_W-1:0] bin_index;
    logic                       opened_new;
    logic                       bins_full;

    modport source (output valid, output placed_id, output bin_index, output opened_new,
                    output bins_full, input ready);
    modport sink   (input valid, input placed_id, input bin_index, input opened_new,
                    input bins_full, output ready);
endinterface

### rtl/bfbp_ram.sv
// Generic simple dual-port RAM with registered read.
module bfbp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/bfbp_ctrl.sv
// Controller state machine: accept, scan the open bins, commit the result.
module bfbp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bfbp_pkg::t_sts i_sts,
    output bfbp_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold the decision until the output register can take it.
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

### rtl/bfbp_dp.sv
// Datapath: capacity register, bin store, best-fit compare and output register.
`include "best_fit_bin_packer_assert.svh"

module bfbp_dp #(
    parameter int MAX_BINS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfbp_pkg::SIZE_W-1:0] i_cfg_wdata,
    input  bfbp_pkg::t_cmd              i_cmd,
    output bfbp_pkg::t_sts              o_sts,
    input  logic                        i_start_run,
    input  logic [bfbp_pkg::ID_W-1:0]   i_item_id,
    input  logic [bfbp_pkg::SIZE_W-1:0] i_item_size,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bfbp_pkg::ID_W-1:0]   o_placed_id,
    output logic [bfbp_pkg::IDX_W-1:0]  o_bin_index,
    output logic                        o_opened_new,
    output logic                        o_bins_full
);
    localparam int AW = $clog2(MAX_BINS);
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int XW = (AW > bfbp_pkg::IDX_W) ? AW : bfbp_pkg::IDX_W;
    localparam int SW = bfbp_pkg::SIZE_W;

    logic [SW-1:0] r_cap;
    logic [CW-1:0] r_open;
    logic [SW-1:0] r_size;
    logic [bfbp_pkg::ID_W-1:0] r_id;
    logic [CW-1:0] r_rd_cnt;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;
    logic          r_found;
    logic [AW-1:0] r_best_idx;
    logic [SW-1:0] r_best_rem;
    logic          r_out_vld;
    logic [bfbp_pkg::ID_W-1:0]  r_out_id;
    logic [bfbp_pkg::IDX_W-1:0] r_out_idx;
    logic          r_out_new;
    logic          r_out_full;

    logic          issue;
    logic [SW-1:0] rem;
    logic          take;
    logic          can_open;
    logic          we;
    logic [AW-1:0] waddr;
    logic [SW-1:0] wdata;
    logic [XW-1:0] chosen_x;

    assign issue    = i_cmd.scan && (r_rd_cnt != r_open);
    assign can_open = (r_open != CW'(MAX_BINS));

    // Equal item size on every bin, so the smallest remaining space that fits
    // also leaves the least over. Strict less keeps the lowest index on a tie.
    assign take = r_cmp_vld && (rem >= r_size) && (!r_found || (rem < r_best_rem));

    assign o_sts.scan_done = (r_rd_cnt == r_open) && !r_cmp_vld;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    always_comb begin
        we       = 1'b0;
        waddr    = r_best_idx;
        wdata    = r_best_rem - r_size;
        chosen_x = XW'(r_best_idx);
        if (i_cmd.commit) begin
            if (r_found) begin
                we = 1'b1;
            end else if (can_open) begin
                we       = 1'b1;
                waddr    = r_open[AW-1:0];
                wdata    = r_cap - r_size;
                chosen_x = XW'(r_open[AW-1:0]);
            end else begin
                chosen_x = '0;
            end
        end
    end

    bfbp_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_cnt[AW-1:0]),
        .o_rdata (rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= '0;
            r_open    <= '0;
            r_rd_cnt  <= '0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_cmp_vld <= issue;
            if (i_cmd.load) begin
                r_rd_cnt <= '0;
                r_found  <= 1'b0;
                if (i_start_run) begin
                    r_open <= '0;
                end
            end else if (issue) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
                if (!r_found && can_open) begin
                    r_open <= r_open + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id   <= i_item_id;
            r_size <= (i_item_size > r_cap) ? r_cap : i_item_size;
        end
        if (issue) begin
            r_cmp_idx <= r_rd_cnt[AW-1:0];
        end
        if (take) begin
            r_best_idx <= r_cmp_idx;
            r_best_rem <= rem;
        end
        if (i_cmd.commit) begin
            r_out_id   <= r_id;
            r_out_idx  <= chosen_x[bfbp_pkg::IDX_W-1:0];
            r_out_new  <= !r_found && can_open;
            r_out_full <= !r_found && !can_open;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_placed_id  = r_out_id;
    assign o_bin_index  = r_out_idx;
    assign o_opened_new = r_out_new;
    assign o_bins_full  = r_out_full;

    `BFBP_ASSERT_NOW(a_open_bound, 1'b1, r_open <= CW'(MAX_BINS))
    `BFBP_ASSERT_NOW(a_scan_bound, 1'b1, r_rd_cnt <= r_open)
    `BFBP_ASSERT_NOW(a_commit_free, i_cmd.commit, !r_out_vld || i_out_ready)
    `BFBP_ASSERT_NEXT(a_commit_out, i_cmd.commit, r_out_vld)
    `BFBP_ASSERT_NOW(a_new_not_full, r_out_vld, !(r_out_new && r_out_full))
endmodule

### rtl/best_fit_bin_packer.sv
// Top level of the best-fit online bin packer.
//
//   Channel  Dir  Handshake        Contents
//   i_item   in   valid / ready    start_run, item_id, item_size
//   o_res    out  valid / ready    placed_id, bin_index, opened_new, bins_full
//   i_cfg    in   write enable     bin_capacity
//
// An item passes through these steps: accept, one bin store read per open bin (at most
// MAX_BINS, none with no bin open) through the single read port, the registered read,
// a step to see the end of the scan, and commit once the output register is free.
// One request is in work at a time; the next is taken once the previous result
// has moved to the output register, even if it is not yet taken.
// Reset is synchronous and clears the capacity and the open bin count.
module best_fit_bin_packer #(
    parameter int MAX_BINS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfbp_pkg::SIZE_W-1:0] i_cfg_wdata,
    bfbp_in_if.sink                     i_item,
    bfbp_out_if.source                  o_res
);
    bfbp_pkg::t_cmd cmd;
    bfbp_pkg::t_sts sts;
    logic           in_ready;

    assign i_item.ready = in_ready;

    bfbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bfbp_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_start_run  (i_item.start_run),
        .i_item_id    (i_item.item_id),
        .i_item_size  (i_item.item_size),
        .o_out_valid  (o_res.valid),
        .i_out_ready  (o_res.ready),
        .o_placed_id  (o_res.placed_id),
        .o_bin_index  (o_res.bin_index),
        .o_opened_new (o_res.opened_new),
        .o_bins_full  (o_res.bins_full)
    );
endmodule

### verif/best_fit_bin_packer_checker.sv
// Watches the bin packer channels, predicts every placement and compares the results.
module best_fit_bin_packer_checker #(
    parameter int MAX_BINS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfbp_pkg::SIZE_W-1:0] i_cfg_wdata,
    bfbp_in_if                          i_item,
    bfbp_out_if                         i_res,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_full_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W   = bfbp_pkg::ID_W;
    localparam int SIZE_W = bfbp_pkg::SIZE_W;
    localparam int IDX_W  = bfbp_pkg::IDX_W;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [IDX_W-1:0] bin;
        logic             opened;
        logic             full;
    } t_placement;

    logic [31:0]       bin_left [MAX_BINS];
    int                bins_open;
    logic [SIZE_W-1:0] capacity;
    t_placement        placements_due [$];
    t_placement        want;
    t_placement        got;
    int                err_count   = 0;
    int                due_count   = 0;
    int                check_count = 0;
    int                full_count  = 0;

    assign o_errors    = err_count;
    assign o_pending   = due_count;
    assign o_checked   = check_count;
    assign o_full_seen = full_count;

    // Best fit: the open bin with the least slack after the item, lowest index on a tie.
    function automatic t_placement place_item(input logic start, input logic [ID_W-1:0] id,
                                              input logic [SIZE_W-1:0] size);
        t_placement  p;
        logic [31:0] need;
        logic [31:0] slack;
        logic [31:0] best_slack;
        int          best;
        bit          found;
        if (start) begin
            bins_open = 0;
        end
        need = (size > capacity) ? {1'b0, capacity} : {1'b0, size};
        found = 0;
        best = 0;
        best_slack = '0;
        for (int b = 0; b < bins_open; b++) begin
            if (bin_left[b] >= need) begin
                slack = bin_left[b] - need;
                if (!found || slack < best_slack) begin
                    found = 1;
                    best = b;
                    best_slack = slack;
                end
            end
        end
        p.id = id;
        p.bin = '0;
        p.opened = 1'b0;
        p.full = 1'b0;
        if (found) begin
            bin_left[best] = best_slack;
            p.bin = IDX_W'(best);
        end else if (bins_open < MAX_BINS) begin
            bin_left[bins_open] = {1'b0, capacity} - need;
            p.bin = IDX_W'(bins_open);
            p.opened = 1'b1;
            bins_open++;
        end else begin
            p.full = 1'b1;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input t_placement exp_p,
                                   input t_placement act_p);
        err_count++;
        if (err_count <= 10) begin
            $display("%s: expected id %h bin %0d new %0b full %0b,",
                     what, exp_p.id, exp_p.bin, exp_p.opened, exp_p.full);
            $display("    got id %h bin %0d new %0b full %0b",
                     act_p.id, act_p.bin, act_p.opened, act_p.full);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bins_open = 0;
            capacity = '0;
            placements_due.delete();
        end else begin
            if (i_cfg_we) begin
                capacity = i_cfg_wdata;
            end
            if (i_item.valid && i_item.ready) begin
                placements_due.insert(placements_due.size(),
                                      place_item(i_item.start_run, i_item.item_id,
                                                 i_item.item_size));
            end
            if (i_res.valid && i_res.ready) begin
                got = {i_res.placed_id, i_res.bin_index, i_res.opened_new, i_res.bins_full};
                check_count++;
                if (got.full) begin
                    full_count++;
                end
                if (placements_due.size() == 0) begin
                    report_mismatch("Result without a request", '0, got);
                end else begin
                    want = placements_due.pop_front();
                    if (got.id !== want.id || got.bin !== want.bin ||
                        got.opened !== want.opened || got.full !== want.full) begin
                        report_mismatch("Placement mismatch", want, got);
                    end
                end
            end
        end
        due_count = placements_due.size();
    end

endmodule

### verif/best_fit_bin_packer_test.sv
// Stimulus and verdict for the best-fit bin packer, with the checker beside the block.
module best_fit_bin_packer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int                ID_W     = bfbp_pkg::ID_W;
    localparam int                SIZE_W   = bfbp_pkg::SIZE_W;
    localparam int                MAX_BINS = 64;
    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    logic              i_clk     = 1'b0;
    logic              i_rst_n   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic [SIZE_W-1:0] cap_now   = '0;
    bit                calm      = 1'b1;
    int                sent      = 0;
    int                cap_writes = 0;
    int                errors;
    int                pending;
    int                checked;
    int                full_seen;

    bfbp_in_if  item_ch ();
    bfbp_out_if res_ch ();

    always #10 i_clk = ~i_clk;

    best_fit_bin_packer #(.MAX_BINS(MAX_BINS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .o_res       (res_ch)
    );

    best_fit_bin_packer_checker #(.MAX_BINS(MAX_BINS)) placement_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_item      (item_ch),
        .i_res       (res_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_full_seen (full_seen)
    );

    function automatic int pick_wait();
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Sizes cluster around the capacity so that bins fill and best fits differ.
    function automatic logic [SIZE_W-1:0] pick_size(input logic [SIZE_W-1:0] cap);
        logic [31:0] span;
        logic [31:0] pick;
        span = {1'b0, cap} + {3'b000, cap[SIZE_W-1:2]};
        case ($urandom_range(0, 9))
            0: pick = '0;
            1: pick = {1'b0, cap};
            2: pick = {1'b0, SIZE_MAX};
            3: pick = $urandom >> 1;
            default: pick = $urandom_range(0, span);
        endcase
        if (pick > {1'b0, SIZE_MAX}) begin
            pick = {1'b0, SIZE_MAX};
        end
        return pick[SIZE_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic push_item(input bit start, input logic [ID_W-1:0] id,
                             input logic [SIZE_W-1:0] size);
        repeat (pick_wait()) @(negedge i_clk);
        item_ch.valid = 1'b1;
        item_ch.start_run = start;
        item_ch.item_id = id;
        item_ch.item_size = size;
        do @(posedge i_clk); while (!item_ch.ready);
        @(negedge i_clk);
        item_ch.valid = 1'b0;
        sent++;
    endtask

    task automatic set_capacity(input logic [SIZE_W-1:0] value);
        cfg_we = 1'b1;
        cfg_wdata = value;
        cap_now = value;
        cap_writes++;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Result side: a random stall before each result, none while calm.
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            stall = pick_wait();
            if (stall > 0) begin
                res_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            @(negedge i_clk);
        end
    end

    initial begin
        #10ms;
        $display("Timed out with %0d results outstanding", pending);
        $display("best_fit_bin_packer_test NOT OK");
        $finish;
    end

    initial begin
        int          run_left;
        int          phase_items;
        bit          long_run;
        bit          start;
        logic [SIZE_W-1:0] size;
        item_ch.valid = 1'b0;
        item_ch.start_run = 1'b0;
        item_ch.item_id = '0;
        item_ch.item_size = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero and oversize items, exact fits, a tie, capacity extremes.
        set_capacity(31'd100);
        push_item(1'b1, 16'h0000, '0);
        push_item(1'b0, 16'hFFFF, SIZE_MAX);
        push_item(1'b0, 16'h0001, '0);
        push_item(1'b0, 16'h0002, 31'd60);
        push_item(1'b0, 16'h0003, 31'd60);
        push_item(1'b0, 16'h0004, 31'd20);
        push_item(1'b0, 16'h0005, 31'd30);
        push_item(1'b0, 16'h0006, 31'd10);
        push_item(1'b0, 16'h0007, 31'd101);
        drain();
        set_capacity(SIZE_MAX);
        push_item(1'b1, 16'h8000, SIZE_MAX);
        push_item(1'b0, 16'h0009, SIZE_MAX);
        push_item(1'b0, 16'h000A, 31'd1);
        push_item(1'b0, 16'h000B, SIZE_MAX - 31'd1);
        drain();
        // Open bins keep their space when the capacity drops to zero mid-run.
        set_capacity('0);
        push_item(1'b0, 16'h000C, 31'd5);
        push_item(1'b1, 16'h000D, 31'd7);
        push_item(1'b0, 16'h000E, '0);
        drain();
        set_capacity(31'd40);
        push_item(1'b0, 16'h000F, 31'd39);
        push_item(1'b0, 16'h5555, 31'h2AAAAAAA);
        push_item(1'b0, 16'hAAAA, 31'h55555555);

        // Random: packing runs of random length, some cut short, over several capacities.
        run_left = 0;
        for (int phase = 0; phase < 8; phase++) begin
            drain();
            long_run = (phase == 0 || phase == 6);
            case (phase)
                0, 6: set_capacity(31'd1);
                1: set_capacity(SIZE_W'($urandom_range(2, 200)));
                2: set_capacity(SIZE_MAX);
                3: set_capacity(SIZE_W'($urandom_range(1, 50)));
                4: set_capacity('0);
                5: set_capacity(SIZE_W'($urandom >> 1));
                default: set_capacity(SIZE_W'($urandom_range(2, 1000)));
            endcase
            calm = (phase == 3);
            phase_items = long_run ? 80 : 60;
            if (long_run) begin
                run_left = 0;
            end
            for (int n = 0; n < phase_items; n++) begin
                start = (run_left == 0) || (!long_run && $urandom_range(0, 19) == 0);
                if (start) begin
                    run_left = long_run ? phase_items : $urandom_range(10, 90);
                end
                // With unit capacity nearly every item opens a bin, so the store fills up.
                if (long_run) begin
                    size = ($urandom_range(0, 9) == 0) ? '0 : SIZE_W'($urandom_range(1, 4));
                end else begin
                    size = pick_size(cap_now);
                end
                push_item(start, ID_W'($urandom_range(0, 65535)), size);
                run_left--;
            end
        end
        calm = 1'b0;

        drain();
        repeat (80) @(negedge i_clk);
        $display("Sent %0d requests under %0d capacity settings, from zero to the 31-bit maximum.",
                 sent, cap_writes);
        $display("Checked %0d placements, %0d of them refused with every bin open.",
                 checked, full_seen);
        if (errors == 0 && pending == 0) begin
            $display("best_fit_bin_packer_test OK");
        end else begin
            $display("best_fit_bin_packer_test NOT OK");
        end
        $finish;
    end

endmodule
